>>> sv/bfc_pkg.sv
// Shared constants and types for the bitmap font text console.
package bfc_pkg;

  // Glyph geometry
  localparam int unsigned GlyphRows  = 16;
  localparam int unsigned GlyphCount = 256;
  localparam int unsigned GlyphWidth = 8;
  localparam int unsigned FontDepth  = GlyphRows * GlyphCount;
  localparam int unsigned FontAw     = $clog2(FontDepth);
  localparam int unsigned RowW       = $clog2(GlyphRows);
  localparam int unsigned XShift     = $clog2(GlyphWidth);
  localparam int unsigned YShift     = $clog2(GlyphRows);
  localparam int unsigned ColourW    = 24;

  // Input function codes
  localparam logic [1:0] FuncFont   = 2'd0;
  localparam logic [1:0] FuncChar   = 2'd1;
  localparam logic [1:0] FuncCursor = 2'd2;

  // Control characters
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Configuration register indexes
  localparam logic [2:0] CfgEnable    = 3'd0;
  localparam logic [2:0] CfgFrameBase = 3'd1;
  localparam logic [2:0] CfgPitch     = 3'd2;
  localparam logic [2:0] CfgBpp       = 3'd3;
  localparam logic [2:0] CfgColumns   = 3'd4;
  localparam logic [2:0] CfgRows      = 3'd5;
  localparam logic [2:0] CfgFg        = 3'd6;
  localparam logic [2:0] CfgBg        = 3'd7;

  // Geometry limits and reset values
  localparam logic [9:0] MaxCols   = 10'd512;
  localparam logic [8:0] MaxRows   = 9'd256;
  localparam logic [9:0] ResetCols = 10'd80;
  localparam logic [8:0] ResetRows = 9'd25;
  localparam logic [2:0] ResetBpp  = 3'd4;

  // Decision taken by the cursor unit for the item on the input
  typedef struct packed {
    logic       draw;
    logic [7:0] glyph;
    logic [8:0] col;
    logic [7:0] line;
  } cursor_cmd_t;

  // Steps of the address generator
  typedef struct packed {
    logic load;
    logic add1;
    logic add2;
    logic step;
  } addr_ctl_t;

endpackage

>>> sv/bfc_font_mem.sv
// Font store: synchronous single-write, single-read memory with registered read data.
module bfc_font_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bfc_pkg::FontAw-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      re_i,
  input  logic [bfc_pkg::FontAw-1:0] raddr_i,
  output logic [7:0]                rdata_o
);
  import bfc_pkg::*;

  logic [7:0] mem_q [FontDepth];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bfc_cursor.sv
// Cursor registers and the per-character decision: what to draw and where the cursor goes.
module bfc_cursor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           func_i,
  input  logic [7:0]           char_i,
  input  logic [8:0]           new_col_i,
  input  logic [7:0]           new_row_i,
  input  logic                 enable_i,
  input  logic [9:0]           text_columns_i,
  input  logic [8:0]           text_rows_i,
  output bfc_pkg::cursor_cmd_t cmd_o,
  output logic [8:0]           cur_col_o,
  output logic [7:0]           cur_line_o
);
  import bfc_pkg::*;

  logic [8:0] cur_col_q, cur_col_d;
  logic [7:0] cur_line_q, cur_line_d;
  logic [9:0] cols;
  logic [8:0] rows;
  logic [9:0] col_w;
  logic [8:0] line_w;
  logic       upd;
  cursor_cmd_t cmd;

  // Clamp the geometry to its legal range
  always_comb begin
    priority if (text_columns_i == 10'd0) cols = 10'd1;
    else if (text_columns_i > MaxCols)    cols = MaxCols;
    else                                  cols = text_columns_i;
    priority if (text_rows_i == 9'd0)     rows = 9'd1;
    else if (text_rows_i > MaxRows)       rows = MaxRows;
    else                                  rows = text_rows_i;
  end

  // Character handling
  always_comb begin
    col_w     = {1'b0, cur_col_q};
    line_w    = {1'b0, cur_line_q};
    upd       = 1'b0;
    cmd.draw  = 1'b0;
    cmd.glyph = char_i;
    cmd.col   = cur_col_q;
    cmd.line  = cur_line_q;
    if (func_i == FuncChar && enable_i) begin
      priority if (char_i == ChBs) begin
        cmd.glyph = 8'd0;
        if (cur_col_q != 9'd0) begin
          col_w    = col_w - 10'd1;
          upd      = 1'b1;
          cmd.draw = 1'b1;
        end else if (cur_line_q != 8'd0) begin
          col_w    = cols - 10'd1;
          line_w   = line_w - 9'd1;
          upd      = 1'b1;
          cmd.draw = 1'b1;
        end
        cmd.col  = col_w[8:0];
        cmd.line = line_w[7:0];
      end else if (char_i == ChCr || char_i == ChLf) begin
        col_w  = 10'd0;
        line_w = line_w + 9'd1;
        upd    = 1'b1;
      end else begin
        cmd.glyph = (char_i == ChTab) ? ChSpace : char_i;
        cmd.draw  = 1'b1;
        col_w     = col_w + 10'd1;
        upd       = 1'b1;
      end
      // wrap to the next line, then to the top
      if (col_w >= cols) begin
        col_w  = 10'd0;
        line_w = line_w + 9'd1;
      end
      if (line_w >= rows) begin
        line_w = 9'd0;
      end
    end
  end

  // Next cursor
  always_comb begin
    cur_col_d  = cur_col_q;
    cur_line_d = cur_line_q;
    if (accept_i && func_i == FuncCursor) begin
      cur_col_d  = new_col_i;
      cur_line_d = new_row_i;
    end else if (accept_i && upd) begin
      cur_col_d  = col_w[8:0];
      cur_line_d = line_w[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= 9'd0;
      cur_line_q <= 8'd0;
    end else begin
      cur_col_q  <= cur_col_d;
      cur_line_q <= cur_line_d;
    end
  end

  assign cmd_o      = cmd;
  assign cur_col_o  = cur_col_q;
  assign cur_line_o = cur_line_q;

endmodule

>>> sv/bfc_addr_gen.sv
// Framebuffer row address: start address over three steps, then one pitch per glyph row.
module bfc_addr_gen (
  input  logic               clk_i,
  input  bfc_pkg::addr_ctl_t ctl_i,
  input  logic [8:0]         col_i,
  input  logic [7:0]         line_i,
  input  logic [31:0]        frame_base_i,
  input  logic [15:0]        line_pitch_i,
  input  logic [2:0]         bpp_i,
  output logic [31:0]        addr_o
);
  import bfc_pkg::*;

  logic [23:0] prod_q;
  logic [11:0] xoff_q;
  logic [31:0] addr_q;

  // Products of the cell position, then the adds, then one pitch per row
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prod_q <= 24'(line_i) * 24'(line_pitch_i);
      xoff_q <= 12'(col_i) * 12'(bpp_i);
    end
    priority if (ctl_i.add1) begin
      addr_q <= frame_base_i + (32'(xoff_q) << XShift);
    end else if (ctl_i.add2) begin
      addr_q <= addr_q + (32'(prod_q) << YShift);
    end else if (ctl_i.step) begin
      addr_q <= addr_q + 32'(line_pitch_i);
    end
  end

  assign addr_o = addr_q;

endmodule

>>> sv/bitmap_font_text_console_core.sv
// Top level of the bitmap font text console: config registers, sequencer, font store, output.
//
// After reset the block clears its 4096-row font store, one row per cycle, and
// takes no item until the clear is done (configuration writes are taken). An
// item that draws nothing (a font write, a cursor set, a carriage return or line
// feed, or a character sent while the console is disabled) is handled in the
// idle state. A drawn character, backspace and tab included, forms the start
// address through the load, ADD1 and ADD2 steps, then emits one glyph row per
// cycle while the output is not stalled; the single read port of the font store
// sets that pace. The next item is taken once the last row has entered the
// output register, which holds a result, cursor included, until it is taken.
module bitmap_font_text_console_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  glyph_row_i,
  input  logic [7:0]  row_bits_i,
  input  logic [8:0]  new_col_i,
  input  logic [7:0]  new_row_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] row_address_o,
  output logic [23:0] pixel0_o,
  output logic [23:0] pixel1_o,
  output logic [23:0] pixel2_o,
  output logic [23:0] pixel3_o,
  output logic [23:0] pixel4_o,
  output logic [23:0] pixel5_o,
  output logic [23:0] pixel6_o,
  output logic [23:0] pixel7_o,
  output logic        last_row_o,
  output logic [8:0]  cursor_col_o,
  output logic [7:0]  cursor_line_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bfc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADD1  = 5'b00100,
    ST_ADD2  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic        enable_q;
  logic [31:0] frame_base_q;
  logic [15:0] line_pitch_q;
  logic [2:0]  bpp_q;
  logic [9:0]  text_columns_q;
  logic [8:0]  text_rows_q;
  logic [23:0] fg_q;
  logic [23:0] bg_q;

  logic [FontAw-1:0] clr_q, clr_d;
  logic [7:0]        glyph_q, glyph_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   rd_row;

  logic        in_accept;
  logic        slot_free;
  logic        emit_load;
  logic        last;
  cursor_cmd_t cmd;
  addr_ctl_t   actl;
  logic [31:0] addr;
  logic [8:0]  cur_col;
  logic [7:0]  cur_line;

  logic              mem_we;
  logic [FontAw-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        mem_rdata;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q;
  logic [7:0]  out_bits_q;
  logic        out_last_q;
  logic [8:0]  out_col_q;
  logic [7:0]  out_line_q;
  logic [ColourW-1:0] pix [GlyphWidth];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit_load   = (state_q == ST_EMIT) && slot_free;
  assign last        = (row_q == RowW'(GlyphRows - 1));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      frame_base_q   <= 32'd0;
      line_pitch_q   <= 16'd0;
      bpp_q          <= ResetBpp;
      text_columns_q <= ResetCols;
      text_rows_q    <= ResetRows;
      fg_q           <= 24'd0;
      bg_q           <= 24'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgEnable:    enable_q       <= cfg_data_i[0];
        CfgFrameBase: frame_base_q   <= cfg_data_i;
        CfgPitch:     line_pitch_q   <= cfg_data_i[15:0];
        CfgBpp:       bpp_q          <= cfg_data_i[2:0];
        CfgColumns:   text_columns_q <= cfg_data_i[9:0];
        CfgRows:      text_rows_q    <= cfg_data_i[8:0];
        CfgFg:        fg_q           <= cfg_data_i[ColourW-1:0];
        CfgBg:        bg_q           <= cfg_data_i[ColourW-1:0];
        default:      enable_q       <= enable_q;
      endcase
    end
  end

  // Cursor and character decision
  bfc_cursor u_cursor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .func_i         (func_i),
    .char_i         (char_code_i),
    .new_col_i      (new_col_i),
    .new_row_i      (new_row_i),
    .enable_i       (enable_q),
    .text_columns_i (text_columns_q),
    .text_rows_i    (text_rows_q),
    .cmd_o          (cmd),
    .cur_col_o      (cur_col),
    .cur_line_o     (cur_line)
  );

  // Address generator steps
  assign actl.load = in_accept && cmd.draw;
  assign actl.add1 = (state_q == ST_ADD1);
  assign actl.add2 = (state_q == ST_ADD2);
  assign actl.step = emit_load;

  bfc_addr_gen u_addr (
    .clk_i        (clk_i),
    .ctl_i        (actl),
    .col_i        (cmd.col),
    .line_i       (cmd.line),
    .frame_base_i (frame_base_q),
    .line_pitch_i (line_pitch_q),
    .bpp_i        (bpp_q),
    .addr_o       (addr)
  );

  // Font store ports: clearing sweep or font write; row reads during a glyph
  assign mem_we    = (state_q == ST_CLEAR) || (in_accept && func_i == FuncFont);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : {char_code_i, glyph_row_i};
  assign mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : row_bits_i;
  assign rd_row    = (state_q == ST_ADD2) ? row_q : row_q + RowW'(1);
  assign mem_re    = (state_q == ST_ADD2) || (emit_load && !last);

  bfc_font_mem u_font (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i ({glyph_q, rd_row}),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    glyph_d = glyph_q;
    row_d   = row_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + FontAw'(1);
        if (clr_q == {FontAw{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept && cmd.draw) begin
          glyph_d = cmd.glyph;
          row_d   = '0;
          state_d = ST_ADD1;
        end
      end
      ST_ADD1: state_d = ST_ADD2;
      ST_ADD2: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          row_d = row_q + RowW'(1);
          if (last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      glyph_q <= 8'd0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      glyph_q <= glyph_d;
      row_q   <= row_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_load)        out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Cursor travels with the row so a later item cannot disturb a waiting result
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_addr_q <= addr;
      out_bits_q <= mem_rdata;
      out_last_q <= last;
      out_col_q  <= cur_col;
      out_line_q <= cur_line;
    end
  end

  // Colours follow the stored row bits; colours are to change only while idle, which the block does not enforce
  always_comb begin
    for (int k = 0; k < GlyphWidth; k++) begin
      pix[k] = out_bits_q[k] ? fg_q : bg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = out_addr_q;
  assign last_row_o    = out_last_q;
  assign cursor_col_o  = out_col_q;
  assign cursor_line_o = out_line_q;
  assign pixel0_o      = pix[0];
  assign pixel1_o      = pix[1];
  assign pixel2_o      = pix[2];
  assign pixel3_o      = pix[3];
  assign pixel4_o      = pix[4];
  assign pixel5_o      = pix[5];
  assign pixel6_o      = pix[6];
  assign pixel7_o      = pix[7];

endmodule

>>> sv/bfc_checker.sv
// Port-level checks for the text console, bound to the top level.
module bfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] row_address_o,
  input logic        last_row_o,
  input logic [8:0]  cursor_col_o,
  input logic [7:0]  cursor_line_o
);

  // The font store is being cleared right after reset: no item is taken
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("item taken while the font store is cleared");

  // Mid-glyph the block stays busy
  a_busy_mid_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |-> !in_ready_o)
    else $error("input ready before the glyph is complete");

  // The cursor does not move while a glyph is still being delivered
  a_cursor_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |=> $stable(cursor_col_o) && $stable(cursor_line_o))
    else $error("cursor moved inside a glyph");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(row_address_o) && $stable(last_row_o))
    else $error("stalled result changed");

endmodule

bind bitmap_font_text_console_core bfc_checker u_bfc_checker (.*);

>>> sim/bfc_glyph_row_checker.sv
// Checker for the text console: predicts glyph row writes and compares them with the output.
`timescale 1ns / 1ps

module bfc_glyph_row_checker
  import bfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input, observed
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  glyph_row_i,
  input  logic [7:0]  row_bits_i,
  input  logic [8:0]  new_col_i,
  input  logic [7:0]  new_row_i,
  // result output, observed
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] row_address_i,
  input  logic [23:0] pixel0_i,
  input  logic [23:0] pixel1_i,
  input  logic [23:0] pixel2_i,
  input  logic [23:0] pixel3_i,
  input  logic [23:0] pixel4_i,
  input  logic [23:0] pixel5_i,
  input  logic [23:0] pixel6_i,
  input  logic [23:0] pixel7_i,
  input  logic        last_row_i,
  input  logic [8:0]  cursor_col_i,
  input  logic [7:0]  cursor_line_i,
  // configuration writes, observed
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // status for the test top
  output int          mismatches_o,
  output int          rows_due_o
);

  // One predicted framebuffer row write
  typedef struct packed {
    logic [31:0]      addr;
    logic [7:0][23:0] pixel;
    logic             last;
    logic [8:0]       col;
    logic [7:0]       line;
  } glyph_row_t;

  glyph_row_t expected_rows[$];

  // Shadow of the font store, cursor and registers
  logic [7:0]  font_rows [FontDepth];
  logic [8:0]  cursor_col;
  logic [7:0]  cursor_line;
  logic        enable;
  logic [31:0] frame_base;
  logic [15:0] line_pitch;
  logic [2:0]  pixel_bytes;
  logic [9:0]  text_cols;
  logic [8:0]  text_lines;
  logic [23:0] fg_colour;
  logic [23:0] bg_colour;
  int          mismatches = 0;

  assign mismatches_o = mismatches;

  // Queue the sixteen row writes of one glyph at a cell
  task automatic draw_glyph(input logic [7:0] glyph, input int dcol, input int dline);
    glyph_row_t  row;
    logic [31:0] y;
    logic [31:0] x_bytes;
    logic [7:0]  bits;
    x_bytes = 32'(dcol) * GlyphWidth * pixel_bytes;
    for (int r = 0; r < GlyphRows; r++) begin
      y = 32'(dline) * GlyphRows + 32'(r);
      bits = font_rows[{glyph, 4'(r)}];
      row.addr = frame_base + y * line_pitch + x_bytes;
      for (int k = 0; k < GlyphWidth; k++) begin
        row.pixel[k] = bits[k] ? fg_colour : bg_colour;
      end
      row.last = (r == GlyphRows - 1);
      row.col  = cursor_col;
      row.line = cursor_line;
      expected_rows.push_back(row);
    end
  endtask

  // Apply one accepted item to the shadow state
  task automatic take_item(input logic [1:0] f, input logic [7:0] ch, input logic [3:0] grow,
                           input logic [7:0] bits, input logic [8:0] ncol,
                           input logic [7:0] nrow);
    int         cols;
    int         rows;
    int         col;
    int         line;
    int         dcol;
    int         dline;
    logic       draw;
    logic       skip;
    logic [7:0] glyph;
    cols  = (text_cols == 0) ? 1 : ((text_cols > MaxCols) ? int'(MaxCols) : int'(text_cols));
    rows  = (text_lines == 0) ? 1 : ((text_lines > MaxRows) ? int'(MaxRows) : int'(text_lines));
    col   = cursor_col;
    line  = cursor_line;
    dcol  = 0;
    dline = 0;
    draw  = 1'b0;
    skip  = 1'b0;
    glyph = '0;
    case (f)
      FuncFont: begin
        font_rows[{ch, grow}] = bits;
      end
      FuncCursor: begin
        cursor_col  = ncol;
        cursor_line = nrow;
      end
      FuncChar: begin
        if (enable) begin
          if (ch == ChBs) begin
            // step back, wrapping to the end of the previous line
            if (col > 0) begin
              col--;
            end else if (line > 0) begin
              col = cols - 1;
              line--;
            end else begin
              skip = 1'b1;
            end
            draw  = !skip;
            dcol  = col;
            dline = line;
          end else if (ch == ChCr || ch == ChLf) begin
            col = 0;
            line++;
          end else begin
            glyph = (ch == ChTab) ? ChSpace : ch;
            draw  = 1'b1;
            dcol  = col;
            dline = line;
            col++;
          end
          if (!skip) begin
            if (col >= cols) begin
              col = 0;
              line++;
            end
            if (line >= rows) line = 0;
            cursor_col  = col[8:0];
            cursor_line = line[7:0];
            if (draw) draw_glyph(glyph, dcol, dline);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      CfgEnable:    enable      = data[0];
      CfgFrameBase: frame_base  = data;
      CfgPitch:     line_pitch  = data[15:0];
      CfgBpp:       pixel_bytes = data[2:0];
      CfgColumns:   text_cols   = data[9:0];
      CfgRows:      text_lines  = data[8:0];
      CfgFg:        fg_colour   = data[23:0];
      CfgBg:        bg_colour   = data[23:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare one accepted row with the oldest prediction
  task automatic check_row();
    glyph_row_t       want;
    logic [7:0][23:0] got_pixel;
    got_pixel = {pixel7_i, pixel6_i, pixel5_i, pixel4_i,
                 pixel3_i, pixel2_i, pixel1_i, pixel0_i};
    if (expected_rows.size() == 0) begin
      $display("%0t: row_address expected none actual %0h", $time, row_address_i);
      mismatches++;
    end else begin
      want = expected_rows.pop_front();
      compare_field("row_address", want.addr, row_address_i);
      for (int k = 0; k < GlyphWidth; k++) begin
        compare_field($sformatf("pixel%0d", k), 32'(want.pixel[k]), 32'(got_pixel[k]));
      end
      compare_field("last_row", 32'(want.last), 32'(last_row_i));
      compare_field("cursor_col", 32'(want.col), 32'(cursor_col_i));
      compare_field("cursor_line", 32'(want.line), 32'(cursor_line_i));
    end
  endtask

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FontDepth; i++) font_rows[i] = '0;
      cursor_col  = '0;
      cursor_line = '0;
      enable      = 1'b0;
      frame_base  = '0;
      line_pitch  = '0;
      pixel_bytes = ResetBpp;
      text_cols   = ResetCols;
      text_lines  = ResetRows;
      fg_colour   = '0;
      bg_colour   = '0;
      expected_rows.delete();
      rows_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_row();
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        take_item(func_i, char_code_i, glyph_row_i, row_bits_i, new_col_i, new_row_i);
      end
      rows_due_o <= expected_rows.size();
    end
  end

endmodule

>>> sim/bitmap_font_text_console_core_test.sv
// Test top for the text console: clock, reset, stimulus, output pacing and verdict.
`timescale 1ns / 1ps

module bitmap_font_text_console_core_test;
  import bfc_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int IdleLimit    = 12000;
  localparam int HoldOff      = 300;
  localparam int SettleCycles = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [7:0]  char_code = '0;
  logic [3:0]  glyph_row = '0;
  logic [7:0]  row_bits = '0;
  logic [8:0]  new_col = '0;
  logic [7:0]  new_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] row_address;
  logic [23:0] pixel0, pixel1, pixel2, pixel3, pixel4, pixel5, pixel6, pixel7;
  logic        last_row;
  logic [8:0]  cursor_col;
  logic [7:0]  cursor_line;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          rows_due;
  int          idle_cycles = 0;
  logic        sender_burst = 1'b0;

  bitmap_font_text_console_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .char_code_i   (char_code),
    .glyph_row_i   (glyph_row),
    .row_bits_i    (row_bits),
    .new_col_i     (new_col),
    .new_row_i     (new_row),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .row_address_o (row_address),
    .pixel0_o      (pixel0),
    .pixel1_o      (pixel1),
    .pixel2_o      (pixel2),
    .pixel3_o      (pixel3),
    .pixel4_o      (pixel4),
    .pixel5_o      (pixel5),
    .pixel6_o      (pixel6),
    .pixel7_o      (pixel7),
    .last_row_o    (last_row),
    .cursor_col_o  (cursor_col),
    .cursor_line_o (cursor_line),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bfc_glyph_row_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .char_code_i   (char_code),
    .glyph_row_i   (glyph_row),
    .row_bits_i    (row_bits),
    .new_col_i     (new_col),
    .new_row_i     (new_row),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .row_address_i (row_address),
    .pixel0_i      (pixel0),
    .pixel1_i      (pixel1),
    .pixel2_i      (pixel2),
    .pixel3_i      (pixel3),
    .pixel4_i      (pixel4),
    .pixel5_i      (pixel5),
    .pixel6_i      (pixel6),
    .pixel7_i      (pixel7),
    .last_row_i    (last_row),
    .cursor_col_i  (cursor_col),
    .cursor_line_i (cursor_line),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .rows_due_o    (rows_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Present one item after a random gap; valid stays up across back-to-back items
  task automatic offer_item(input logic [1:0] f, input logic [7:0] c, input logic [3:0] g,
                            input logic [7:0] b, input logic [8:0] nc, input logic [7:0] nr);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    char_code <= c;
    glyph_row <= g;
    row_bits  <= b;
    new_col   <= nc;
    new_row   <= nr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_char(input logic [7:0] c);
    offer_item(FuncChar, c, 4'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register; only called while the console is idle
  task automatic configure(input logic [31:0] en, input logic [31:0] base,
                           input logic [31:0] pitch, input logic [31:0] bpp,
                           input logic [31:0] cols, input logic [31:0] rows,
                           input logic [31:0] fg, input logic [31:0] bg);
    write_reg(CfgEnable, en);
    write_reg(CfgFrameBase, base);
    write_reg(CfgPitch, pitch);
    write_reg(CfgBpp, bpp);
    write_reg(CfgColumns, cols);
    write_reg(CfgRows, rows);
    write_reg(CfgFg, fg);
    write_reg(CfgBg, bg);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every predicted row, then for the tail of a silent item
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_due != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly characters, with font writes, cursor moves and the unused code mixed in
  task automatic random_item();
    int         pick;
    int         sel;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0, 1:    c = ChBs;
        2:       c = ChCr;
        3:       c = ChLf;
        4:       c = ChTab;
        default: c = 8'($urandom_range(0, 255));
      endcase
      put_char(c);
    end else if (pick < 77) begin
      offer_item(FuncFont, 8'($urandom), 4'($urandom), 8'($urandom),
                 9'($urandom), 8'($urandom));
    end else if (pick < 92) begin
      offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom),
                 $urandom_range(0, 1) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 8)),
                 $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4)));
    end else begin
      offer_item(FuncUnused, 8'($urandom), 4'($urandom), 8'($urandom),
                 9'($urandom), 8'($urandom));
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // console still disabled: character dropped, font and cursor still act
    put_char(8'h41);
    offer_item(FuncFont, 8'h41, 4'd0, 8'hFF, 9'($urandom), 8'($urandom));
    offer_item(FuncFont, 8'h41, 4'd15, 8'h81, 9'($urandom), 8'($urandom));
    offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom), 9'd3, 8'd2);
    settle();

    configure(32'h1, 32'h1000_0000, 32'd2560, 32'd4, 32'd80, 32'd25,
              32'h00FF_FFFF, 32'h0);
    offer_item(FuncFont, 8'h00, 4'd0, 8'h01, 9'($urandom), 8'($urandom));
    offer_item(FuncFont, 8'hFF, 4'd7, 8'hAA, 9'($urandom), 8'($urandom));
    offer_item(FuncFont, ChSpace, 4'd3, 8'h55, 9'($urandom), 8'($urandom));
    offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom), 9'd0, 8'd0);
    put_char(ChBs);                 // top-left: nothing happens
    put_char(8'h41);
    put_char(8'h00);                // code zero draws glyph zero
    put_char(8'hFF);                // high codes index the upper glyphs
    put_char(ChTab);
    put_char(ChBs);
    put_char(ChCr);
    put_char(ChLf);
    offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom), 9'd79, 8'd24);
    put_char(8'h41);                // last cell wraps to the top
    offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom), 9'd0, 8'd1);
    put_char(ChBs);                 // back onto the previous line
    offer_item(FuncCursor, 8'($urandom), 4'($urandom), 8'($urandom), 9'd511, 8'd255);
    put_char(8'hFF);                // cell beyond the screen
    offer_item(FuncUnused, 8'hFF, 4'hF, 8'hFF, 9'h1FF, 8'hFF);

    // random phases under different settings
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: configure(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'hFF00_0000, 32'h00FF_FFFF);
        1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        3: configure(32'hFFFF_FFFE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        default: configure($urandom | 32'h1, $urandom, $urandom, $urandom,
                           $urandom_range(1, 12), $urandom_range(1, 6),
                           $urandom, $urandom);
      endcase
      sender_burst = (p == 2);
      for (int i = 0; i < ((p == 3) ? 20 : 77); i++) random_item();
    end
    sender_burst = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("bitmap_font_text_console_core test passed");
    end else begin
      $display("bitmap_font_text_console_core test failed");
    end
    $finish;
  end

  // Result pacing: random stalls, a stretch without stalls and two long hold-offs
  initial begin
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken == 60 || taken == 1500) gap = HoldOff;
      else if (taken >= 150 && taken < 400) gap = 0;
      else gap = $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("bitmap_font_text_console_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
sv/bfc_pkg.sv
sv/bfc_font_mem.sv
sv/bfc_cursor.sv
sv/bfc_addr_gen.sv
sv/bitmap_font_text_console_core.sv
sv/bfc_checker.sv
sim/bfc_glyph_row_checker.sv
sim/bitmap_font_text_console_core_test.sv
